@@ hw/rtl/vehicle_presence_fsm_core_assert.svh @@
// Assertion macros shared by the presence detector RTL.
`ifndef VEHICLE_PRESENCE_FSM_CORE_ASSERT_SVH
`define VEHICLE_PRESENCE_FSM_CORE_ASSERT_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define VPF_ASSERT_IMPLY(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("presence detector implication violated");

// The condition must never hold outside reset.
`define VPF_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("presence detector forbidden condition seen");

`endif

@@ hw/rtl/vpf_pkg.sv @@
// Package with the constants, codes and types of the vehicle presence detector.
`default_nettype none

package vpf_pkg;

    // Echo timing and field widths.
    localparam int unsigned ECHO_W  = 15;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned INDEX_W = 2;

    // Readings above this many microseconds count as no echo.
    localparam logic [15:0] ECHO_TIMEOUT_US = 16'd30000;

    // Presence state codes.
    localparam logic [STATE_W-1:0] ST_UNKNOWN  = 3'd0;
    localparam logic [STATE_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATE_W-1:0] ST_ENTRY    = 3'd2;
    localparam logic [STATE_W-1:0] ST_OCCUPIED = 3'd3;
    localparam logic [STATE_W-1:0] ST_EXIT     = 3'd4;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_NEAR_LIMIT = 2'd0;
    localparam logic [INDEX_W-1:0] REG_FAR_LIMIT  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_CONFIRM    = 2'd2;

    // Configuration reset values (100 cm and 120 cm as echo times).
    localparam logic [ECHO_W-1:0]  NEAR_LIMIT_RESET = 15'd5831;
    localparam logic [ECHO_W-1:0]  FAR_LIMIT_RESET  = 15'd6997;
    localparam logic [COUNT_W-1:0] CONFIRM_RESET    = 4'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 4'd15;

    // Configuration seen by the step logic.
    typedef struct packed {
        logic [ECHO_W-1:0]  near_limit;
        logic [ECHO_W-1:0]  far_limit;
        logic [COUNT_W-1:0] confirm;
    } vpf_cfg_t;

    // Outcome of one reading.
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [COUNT_W-1:0] count;
        logic               entered;
        logic               exited;
    } vpf_step_t;

endpackage

`default_nettype wire

@@ hw/rtl/vehicle_presence_fsm_core.sv @@
// Top level of the vehicle presence detector with hysteresis and confirmation.
//
// Usage: one ultrasonic echo time (microseconds, 0 = no echo) enters per beat on
// the input channel (in_valid / in_stall). Every input beat yields exactly one
// output beat (out_valid / out_stall) with the presence state, candidate count,
// entry and exit pulses and the running total of confirmed exits.
// The reading is captured in an input register, and the state update is written
// to the result register when that register advances.
// Throughput is one reading per cycle while the receiver does not stall; the
// limit is the presence machine's state loop, through two compares and a 4-bit add.
// When the receiver stalls, the result register holds and the input register
// keeps one more reading; in_stall rises only when both are occupied.
// Reset clears the machine to unknown, the counter and the exit total to zero,
// and loads the default limits (5831 us near, 6997 us far, 3 confirmations).
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 is the near limit, 1 the far limit, 2 the confirmation
// count. Write it only while no reading is in flight.
`default_nettype none

module vehicle_presence_fsm_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [vpf_pkg::ECHO_W-1:0]   echo_time_us,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [vpf_pkg::STATE_W-1:0]       presence_state,
    output logic [vpf_pkg::COUNT_W-1:0]       candidate_count,
    output logic                              entered_pulse,
    output logic                              exited_pulse,
    output logic [vpf_pkg::TOTAL_W-1:0]       vehicle_total,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [vpf_pkg::INDEX_W-1:0]  cfg_index,
    input  wire logic [vpf_pkg::ECHO_W-1:0]   cfg_data
);
    import vpf_pkg::*;

    `include "vehicle_presence_fsm_core_assert.svh"

    logic               in_full_reg;
    logic [ECHO_W-1:0]  echo_reg;
    logic               out_full_reg;
    logic [STATE_W-1:0] state_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               entered_reg;
    logic               exited_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    vpf_cfg_t           cfg_reg;
    vpf_step_t          step;
    logic               advance;
    logic               take_in;

    // The input register moves on whenever the result register is free or drained.
    assign advance  = !out_full_reg || !out_stall;
    assign in_stall = in_full_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit <= NEAR_LIMIT_RESET;
            cfg_reg.far_limit  <= FAR_LIMIT_RESET;
            cfg_reg.confirm    <= CONFIRM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NEAR_LIMIT: cfg_reg.near_limit <= cfg_data;
                REG_FAR_LIMIT:  cfg_reg.far_limit  <= cfg_data;
                REG_CONFIRM:    cfg_reg.confirm    <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            echo_reg <= echo_time_us;
        end
    end

    // Presence machine step on the held reading.
    vpf_step u_step (
        .echo   (echo_reg),
        .state  (state_reg),
        .count  (count_reg),
        .cfg    (cfg_reg),
        .result (step)
    );

    assign total_next = total_reg + {{(TOTAL_W-1){1'b0}}, step.exited};

    // State and result register; the state registers double as the result fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
            state_reg    <= ST_UNKNOWN;
            count_reg    <= '0;
            entered_reg  <= 1'b0;
            exited_reg   <= 1'b0;
            total_reg    <= '0;
        end
        else if (advance)
        begin
            out_full_reg <= in_full_reg;
            if (in_full_reg)
            begin
                state_reg   <= step.state;
                count_reg   <= step.count;
                entered_reg <= step.entered;
                exited_reg  <= step.exited;
                total_reg   <= total_next;
            end
        end
    end

    assign out_valid       = out_full_reg;
    assign presence_state  = state_reg;
    assign candidate_count = count_reg;
    assign entered_pulse   = entered_reg;
    assign exited_pulse    = exited_reg;
    assign vehicle_total   = total_reg;

    // Checks on the machine and the exit total.
    `VPF_ASSERT_NEVER(a_pulses_exclusive, out_full_reg && entered_reg && exited_reg)
    `VPF_ASSERT_IMPLY(a_entry_lands_occupied, out_full_reg && entered_reg,
        state_reg == ST_OCCUPIED && count_reg == '0)
    `VPF_ASSERT_IMPLY(a_exit_lands_empty, out_full_reg && exited_reg,
        state_reg == ST_EMPTY && count_reg == '0)
    `VPF_ASSERT_IMPLY(a_total_steps_on_exit, total_reg != $past(total_reg),
        exited_reg && total_reg == $past(total_reg) + 32'd1)

endmodule

`default_nettype wire

@@ hw/rtl/vpf_step.sv @@
// Next-state logic of the presence machine for one echo reading.
`default_nettype none

module vpf_step (
    input  wire logic [vpf_pkg::ECHO_W-1:0]  echo,
    input  wire logic [vpf_pkg::STATE_W-1:0] state,
    input  wire logic [vpf_pkg::COUNT_W-1:0] count,
    input  wire vpf_pkg::vpf_cfg_t           cfg,
    output vpf_pkg::vpf_step_t               result
);
    import vpf_pkg::*;

    logic               echo_ok;
    logic               is_near;
    logic               is_far;
    logic [COUNT_W-1:0] bumped;
    logic               confirmed;

    // Classify the reading; zero or past timeout is no echo.
    assign echo_ok = (echo != '0) && ({1'b0, echo} <= ECHO_TIMEOUT_US);
    assign is_near = echo_ok && (echo < cfg.near_limit);
    assign is_far  = echo_ok && (echo > cfg.far_limit);

    // Saturating counter step and the confirmation test on it.
    assign bumped    = (count == COUNT_MAX) ? COUNT_MAX : count + 4'd1;
    assign confirmed = (bumped >= cfg.confirm);

    // Transition table.
    always_comb
    begin
        result.state   = state;
        result.count   = count;
        result.entered = 1'b0;
        result.exited  = 1'b0;
        case (state)
            ST_UNKNOWN:
            begin
                if (is_near)
                begin
                    result.state = ST_OCCUPIED;
                end
                else if (is_far)
                begin
                    result.state = ST_EMPTY;
                end
            end
            ST_EMPTY:
            begin
                if (is_near)
                begin
                    result.state = ST_ENTRY;
                    result.count = 4'd1;
                end
            end
            ST_ENTRY:
            begin
                if (is_near)
                begin
                    result.count = bumped;
                    if (confirmed)
                    begin
                        result.state   = ST_OCCUPIED;
                        result.count   = '0;
                        result.entered = 1'b1;
                    end
                end
                else
                begin
                    result.state = ST_EMPTY;
                    result.count = '0;
                end
            end
            ST_OCCUPIED:
            begin
                if (is_far)
                begin
                    result.state = ST_EXIT;
                    result.count = 4'd1;
                end
            end
            ST_EXIT:
            begin
                if (is_far)
                begin
                    result.count = bumped;
                    if (confirmed)
                    begin
                        result.state  = ST_EMPTY;
                        result.count  = '0;
                        result.exited = 1'b1;
                    end
                end
                else
                begin
                    result.state = ST_OCCUPIED;
                    result.count = '0;
                end
            end
            default:
            begin
                result.state = ST_UNKNOWN;
                result.count = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ verif/presence_monitor.sv @@
`timescale 1ns / 100ps
// Checker for the presence detector: predicts each result beat and compares it.

module presence_monitor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [vpf_pkg::ECHO_W-1:0]    echo_time_us,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [vpf_pkg::STATE_W-1:0]   presence_state,
    input  wire logic [vpf_pkg::COUNT_W-1:0]   candidate_count,
    input  wire logic                          entered_pulse,
    input  wire logic                          exited_pulse,
    input  wire logic [vpf_pkg::TOTAL_W-1:0]   vehicle_total,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [vpf_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [vpf_pkg::ECHO_W-1:0]    cfg_data,
    output int                                 backlog,
    output int                                 fail_count
);
    import vpf_pkg::*;

    // One expected result beat: the step outcome plus the running exit total.
    typedef struct packed {
        vpf_step_t          step;
        logic [TOTAL_W-1:0] total;
    } presence_report_t;

    // Shadow configuration and machine state.
    logic [ECHO_W-1:0]  lim_near     = NEAR_LIMIT_RESET;
    logic [ECHO_W-1:0]  lim_far      = FAR_LIMIT_RESET;
    logic [COUNT_W-1:0] need_confirm = CONFIRM_RESET;
    logic [STATE_W-1:0] pres_state   = ST_UNKNOWN;
    logic [COUNT_W-1:0] cand_count   = '0;
    logic [TOTAL_W-1:0] exit_total   = '0;

    presence_report_t pending_reports[$];
    int errors = 0;

    // Apply one reading to the shadow machine and return the result it yields.
    task automatic advance_presence(input logic [ECHO_W-1:0] echo,
                                    output presence_report_t report);
        logic usable;
        logic is_near;
        logic is_far;
        logic entered;
        logic exited;
        usable  = (echo != '0) && ({1'b0, echo} <= ECHO_TIMEOUT_US);
        is_near = usable && (echo < lim_near);
        is_far  = usable && (echo > lim_far);
        entered = 1'b0;
        exited  = 1'b0;
        case (pres_state)
            ST_UNKNOWN:
            begin
                // Near wins when crossed limits make a reading both near and far.
                if (is_near)
                    pres_state = ST_OCCUPIED;
                else if (is_far)
                    pres_state = ST_EMPTY;
            end
            ST_EMPTY:
            begin
                if (is_near)
                begin
                    pres_state = ST_ENTRY;
                    cand_count = 4'd1;
                end
            end
            ST_ENTRY:
            begin
                if (is_near)
                begin
                    cand_count = (cand_count == COUNT_MAX) ? COUNT_MAX : cand_count + 1'b1;
                    if (cand_count >= need_confirm)
                    begin
                        pres_state = ST_OCCUPIED;
                        cand_count = '0;
                        entered    = 1'b1;
                    end
                end
                else
                begin
                    pres_state = ST_EMPTY;
                    cand_count = '0;
                end
            end
            ST_OCCUPIED:
            begin
                if (is_far)
                begin
                    pres_state = ST_EXIT;
                    cand_count = 4'd1;
                end
            end
            ST_EXIT:
            begin
                if (is_far)
                begin
                    cand_count = (cand_count == COUNT_MAX) ? COUNT_MAX : cand_count + 1'b1;
                    if (cand_count >= need_confirm)
                    begin
                        pres_state = ST_EMPTY;
                        cand_count = '0;
                        exited     = 1'b1;
                    end
                end
                else
                begin
                    pres_state = ST_OCCUPIED;
                    cand_count = '0;
                end
            end
            default:
            begin
                pres_state = ST_UNKNOWN;
                cand_count = '0;
            end
        endcase
        if (exited)
            exit_total = exit_total + 1'b1;
        report.step.state   = pres_state;
        report.step.count   = cand_count;
        report.step.entered = entered;
        report.step.exited  = exited;
        report.total        = exit_total;
    endtask

    // Report one field that differs from its expected value.
    task automatic compare_field(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
        end
    endtask

    // Watch the three channels; configuration first, then readings, then results.
    always @(posedge clk or negedge rst_n)
    begin : watch
        presence_report_t want;
        if (!rst_n)
        begin
            lim_near     = NEAR_LIMIT_RESET;
            lim_far      = FAR_LIMIT_RESET;
            need_confirm = CONFIRM_RESET;
            pres_state   = ST_UNKNOWN;
            cand_count   = '0;
            exit_total   = '0;
            pending_reports.delete();
            backlog <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NEAR_LIMIT: lim_near     = cfg_data;
                    REG_FAR_LIMIT:  lim_far      = cfg_data;
                    REG_CONFIRM:    need_confirm = cfg_data[COUNT_W-1:0];
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance_presence(echo_time_us, want);
                pending_reports.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected, state %0d total %0d",
                             $time, presence_state, vehicle_total);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    compare_field("presence_state", 32'(want.step.state),
                                  32'(presence_state));
                    compare_field("candidate_count", 32'(want.step.count),
                                  32'(candidate_count));
                    compare_field("entered_pulse", 32'(want.step.entered),
                                  32'(entered_pulse));
                    compare_field("exited_pulse", 32'(want.step.exited),
                                  32'(exited_pulse));
                    compare_field("vehicle_total", want.total, vehicle_total);
                end
            end
            backlog    <= pending_reports.size();
            fail_count <= errors;
        end
    end

endmodule

@@ verif/vehicle_presence_fsm_core_test.sv @@
`timescale 1ns / 100ps
// Top of the presence detector testbench: clock, reset, stimulus and verdict.

module vehicle_presence_fsm_core_test;
    import vpf_pkg::*;

    localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int GAP_MAX        = 17;
    localparam int SQUEEZE_CYCLES = 80;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 100;
    localparam int CYCLE_LIMIT    = 400000;

    typedef enum int {RD_NEAR, RD_FAR, RD_MID, RD_VOID, RD_ANY} reading_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ECHO_W-1:0]    echo_time_us = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATE_W-1:0]   presence_state;
    logic [COUNT_W-1:0]   candidate_count;
    logic                 entered_pulse;
    logic                 exited_pulse;
    logic [TOTAL_W-1:0]   vehicle_total;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [INDEX_W-1:0]   cfg_index = '0;
    logic [ECHO_W-1:0]    cfg_data = '0;

    int backlog;
    int fail_count;
    int cycle_count = 0;
    int sent = 0;
    bit quiet = 1'b0;
    bit squeeze_req = 1'b0;

    // Limits currently programmed, used only to shape the readings.
    int cur_near = NEAR_LIMIT_RESET;
    int cur_far  = FAR_LIMIT_RESET;
    int cur_conf = CONFIRM_RESET;

    vehicle_presence_fsm_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .echo_time_us    (echo_time_us),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .presence_state  (presence_state),
        .candidate_count (candidate_count),
        .entered_pulse   (entered_pulse),
        .exited_pulse    (exited_pulse),
        .vehicle_total   (vehicle_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    presence_monitor u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .echo_time_us    (echo_time_us),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .presence_state  (presence_state),
        .candidate_count (candidate_count),
        .entered_pulse   (entered_pulse),
        .exited_pulse    (exited_pulse),
        .vehicle_total   (vehicle_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .backlog         (backlog),
        .fail_count      (fail_count)
    );

    // 50 MHz clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result receiver: a random stall before each beat, or a long hold-off on request.
    initial
    begin : receiver
        int hold;
        forever
        begin
            if (squeeze_req)
            begin
                hold = SQUEEZE_CYCLES;
                squeeze_req = 1'b0;
            end
            else
            begin
                hold = quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Offer one reading after a random gap and wait until the beat is taken.
    task automatic send_echo(input logic [ECHO_W-1:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        echo_time_us <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // Stop offering and wait until every result beat has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the three registers back to back, and the unused index if asked.
    task automatic apply_settings(input logic [ECHO_W-1:0] near, input logic [ECHO_W-1:0] far,
                                  input logic [ECHO_W-1:0] conf, input bit spare);
        logic [INDEX_W-1:0] idx[4];
        logic [ECHO_W-1:0]  val[4];
        int last;
        idx  = '{REG_NEAR_LIMIT, REG_FAR_LIMIT, REG_CONFIRM, REG_SPARE};
        val  = '{near, far, conf, ECHO_W'($urandom_range(0, 32767))};
        last = spare ? 3 : 2;
        for (int i = 0; i <= last; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_near = int'(near);
        cur_far  = int'(far);
        cur_conf = int'(conf[COUNT_W-1:0]);
    endtask

    // Draw an echo time of the given kind under the current limits.
    function automatic logic [ECHO_W-1:0] pick_echo(input reading_kind_t kind);
        int lo;
        int hi;
        lo = 0;
        hi = 32767;
        case (kind)
            RD_NEAR:
            begin
                lo = 1;
                hi = (cur_near - 1 > 30000) ? 30000 : cur_near - 1;
            end
            RD_FAR:
            begin
                lo = cur_far + 1;
                hi = 30000;
            end
            RD_MID:
            begin
                lo = (cur_near < 1) ? 1 : cur_near;
                hi = (cur_far > 30000) ? 30000 : cur_far;
            end
            RD_VOID:
            begin
                if ($urandom_range(0, 1) == 0)
                    return '0;
                lo = 30001;
            end
            default: ;
        endcase
        if (lo > hi)
        begin
            lo = 0;
            hi = 32767;
        end
        return ECHO_W'($urandom_range(hi, lo));
    endfunction

    // Mostly the wanted kind, now and then any other.
    function automatic reading_kind_t noisy_kind(input reading_kind_t kind);
        if ($urandom_range(0, 11) == 0)
            return reading_kind_t'($urandom_range(0, 4));
        return kind;
    endfunction

    // Vehicles arriving and leaving, with noise between passages.
    task automatic run_passages(input int count);
        int stop;
        int n;
        stop = sent + count;
        while (sent < stop)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_echo(pick_echo(reading_kind_t'($urandom_range(0, 4))));
            end
            else
            begin
                n = $urandom_range(1, cur_conf + 2);
                repeat (n) send_echo(pick_echo(noisy_kind(RD_NEAR)));
                n = $urandom_range(1, cur_conf + 2);
                repeat (n) send_echo(pick_echo(noisy_kind(RD_FAR)));
            end
        end
    endtask

    // Random register settings, usually with the near limit below the far one.
    task automatic random_settings();
        int near;
        int far;
        int swap;
        int conf;
        near = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 32767 : 0)
                                            : $urandom_range(1, 30000);
        far  = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 32767 : 0)
                                            : $urandom_range(1, 30000);
        if (near > far && $urandom_range(0, 4) != 0)
        begin
            swap = near;
            near = far;
            far  = swap;
        end
        conf = $urandom_range(0, 15);
        if ($urandom_range(0, 2) == 0)
            conf = conf | ($urandom_range(0, 2047) << COUNT_W);
        apply_settings(ECHO_W'(near), ECHO_W'(far), ECHO_W'(conf), $urandom_range(0, 3) == 0);
    endtask

    // Stimulus: directed cases, then random phases, then the verdict.
    initial
    begin : stimulus
        logic [ECHO_W-1:0] crossed_run[5];
        logic [ECHO_W-1:0] default_run[14];
        crossed_run = '{15000, 15000, 15000, 15000, 15000};
        default_run = '{6998, 0, 6998, 6998, 30000, 32767, 30001,
                        5831, 6997, 5830, 6000, 5830, 1, 5830};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Crossed limits from the unknown state with a zero confirmation count;
        // the upper data bits of the confirmation write must be dropped.
        apply_settings(15'd20000, 15'd10000, 15'h7FF0, 1'b1);
        foreach (crossed_run[i])
            send_echo(crossed_run[i]);
        settle();

        // Default limits: aborted exit, full exit, timeout readings, the exact
        // threshold values, aborted entry and full entry.
        apply_settings(NEAR_LIMIT_RESET, FAR_LIMIT_RESET, ECHO_W'(CONFIRM_RESET), 1'b0);
        foreach (default_run[i])
            send_echo(default_run[i]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0: apply_settings(NEAR_LIMIT_RESET, FAR_LIMIT_RESET, ECHO_W'(CONFIRM_RESET), 1'b0);
                1: apply_settings(15'd0, 15'd0, 15'd1, 1'b0);
                2: apply_settings(15'd32767, 15'd32767, 15'd15, 1'b0);
                3: apply_settings(15'd30000, 15'd1, 15'd0, 1'b0);
                4: apply_settings(15'd2, 15'd29999, 15'd15, 1'b0);
                default: random_settings();
            endcase
            quiet = ($urandom_range(0, 3) == 0);

            // Back-to-back readings against a long receiver hold-off.
            if (phase == 0 || phase == 6)
            begin
                quiet = 1'b1;
                squeeze_req = 1'b1;
                run_passages(30);
                quiet = 1'b0;
            end
            run_passages(PHASE_ITEMS);
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
